// ----- rtl/csrs_pkg.sv -----
`timescale 1ns / 1ps

package csrs_pkg;

  // Instruction and event codes carried in the opcode field.
  localparam logic [1:0] OP_PING   = 2'd0;
  localparam logic [1:0] OP_ENTRY  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_ID       = 2'd0;
  localparam logic [1:0] CFG_PING_SLOT    = 2'd1;
  localparam logic [1:0] CFG_READ_TIMEOUT = 2'd2;

  // Encoded wait_mode values on the result channel.
  localparam logic [1:0] WAIT_IDLE = 2'd0;
  localparam logic [1:0] WAIT_PING = 2'd1;
  localparam logic [1:0] WAIT_READ = 2'd2;

  localparam logic [7:0]  NO_PRED           = 8'hFF;
  localparam logic [7:0]  OWN_ID_RESET      = 8'd1;
  localparam logic [15:0] PING_SLOT_RESET   = 16'd3000;
  localparam logic [15:0] READ_TIMEOUT_RESET = 16'd50000;
  localparam logic [15:0] TICKS_MAX         = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_PING = 3'b010,
    MODE_READ = 3'b100
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  slot_id;
    logic [7:0]  predecessor_id;
    logic        own_found;
    logic [15:0] elapsed_ticks;
  } sched_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] entry_id;
    logic       first_entry;
    logic       last_entry;
    logic [7:0] status_source;
  } item_t;

  typedef struct packed {
    logic       send_response;
    logic       response_dropped;
    logic [1:0] wait_mode;
  } result_t;

  typedef struct packed {
    logic [7:0]  own_id;
    logic [15:0] ping_slot_ticks;
    logic [15:0] read_timeout_ticks;
  } cfg_t;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] code;
    case (m)
      MODE_IDLE: code = WAIT_IDLE;
      MODE_PING: code = WAIT_PING;
      MODE_READ: code = WAIT_READ;
      default:   code = WAIT_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/csrs_step.sv -----
`timescale 1ns / 1ps

// Next-state and result logic for one item.
module csrs_step (
  input  csrs_pkg::cfg_t         cfg,
  input  csrs_pkg::sched_state_t state,
  input  csrs_pkg::item_t        item,
  output csrs_pkg::sched_state_t state_next,
  output csrs_pkg::result_t      result
);

  logic [15:0] ticks_inc;
  logic        send;
  logic        dropped;
  logic        found_next;
  logic [7:0]  pred_next;

  // Saturating tick count.
  assign ticks_inc = (state.elapsed_ticks == csrs_pkg::TICKS_MAX) ?
                     state.elapsed_ticks : state.elapsed_ticks + 16'd1;

  always_comb begin
    state_next = state;
    send       = 1'b0;
    dropped    = 1'b0;
    found_next = state.own_found;
    pred_next  = state.predecessor_id;

    case (state.mode)
      csrs_pkg::MODE_IDLE: begin
        if (item.opcode == csrs_pkg::OP_PING) begin
          state_next.mode          = csrs_pkg::MODE_PING;
          state_next.slot_id       = 8'd1;
          state_next.elapsed_ticks = '0;
        end else if (item.opcode == csrs_pkg::OP_ENTRY) begin
          // Restart the scan on the first entry.
          if (item.first_entry) begin
            pred_next  = csrs_pkg::NO_PRED;
            found_next = 1'b0;
          end
          if (!found_next) begin
            if (item.entry_id == cfg.own_id) begin
              found_next = 1'b1;
            end else begin
              pred_next = item.entry_id;
            end
          end
          state_next.own_found      = found_next;
          state_next.predecessor_id = pred_next;
          if (item.last_entry && found_next) begin
            if (pred_next == csrs_pkg::NO_PRED) begin
              send = 1'b1;
            end else begin
              state_next.mode          = csrs_pkg::MODE_READ;
              state_next.elapsed_ticks = '0;
            end
          end
        end
      end
      csrs_pkg::MODE_PING: begin
        if (item.opcode == csrs_pkg::OP_STATUS) begin
          state_next.slot_id = item.status_source + 8'd1;
        end else if (item.opcode == csrs_pkg::OP_TICK) begin
          if (ticks_inc >= cfg.ping_slot_ticks) begin
            state_next.elapsed_ticks = '0;
            state_next.slot_id       = state.slot_id + 8'd1;
          end else begin
            state_next.elapsed_ticks = ticks_inc;
          end
        end
      end
      csrs_pkg::MODE_READ: begin
        if (item.opcode == csrs_pkg::OP_STATUS) begin
          state_next.elapsed_ticks = '0;
          if (item.status_source == state.predecessor_id) begin
            send            = 1'b1;
            state_next.mode = csrs_pkg::MODE_IDLE;
          end
        end else if (item.opcode == csrs_pkg::OP_TICK) begin
          state_next.elapsed_ticks = ticks_inc;
          if (ticks_inc >= cfg.read_timeout_ticks) begin
            dropped         = 1'b1;
            state_next.mode = csrs_pkg::MODE_IDLE;
          end
        end
      end
      default: begin
        state_next.mode = csrs_pkg::MODE_IDLE;
      end
    endcase

    // Our slot came up: reply and leave ping mode.
    if (state_next.mode == csrs_pkg::MODE_PING && state_next.slot_id == cfg.own_id) begin
      send            = 1'b1;
      state_next.mode = csrs_pkg::MODE_IDLE;
    end

    result.send_response    = send;
    result.response_dropped = dropped;
    result.wait_mode        = csrs_pkg::mode_code(state_next.mode);
  end

endmodule

// ----- rtl/chained_status_response_scheduler_core.sv -----
`timescale 1ns / 1ps

// Status reply scheduler for one node on a shared half-duplex bus.
//
// Input channel (in_valid / in_stall): one item per bus event: a broadcast
// ping, one entry of a sync/bulk read ID list, an observed status packet,
// or a timer tick. Output channel (out_valid / out_stall): exactly one
// result item per input item, in order: send_response, response_dropped
// and the wait mode after the event.
// Configuration channel (cfg_valid / cfg_ready, always ready): writes own
// ID, ping slot length and read timeout by index; index 3 is ignored.
// Write it only while no items are in flight.
//
// An accepted item sits in the input register and then moves into the
// result register, which raises out_valid so that the result can be taken.
// One item per cycle is sustained while out_stall is low; the input register
// keeps accepting while the result register holds an untaken result, as
// long as the result register frees up in the same cycle.
// When out_stall is high the result holds, the input register holds its
// item, and in_stall rises once the input register is occupied.
// Synchronous reset clears both pipeline stages, returns the scheduler to
// idle with no predecessor and restores the register reset values.
module chained_status_response_scheduler_core (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  entry_id,
  input  logic        first_entry,
  input  logic        last_entry,
  input  logic [7:0]  status_source,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        send_response,
  output logic        response_dropped,
  output logic [1:0]  wait_mode,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  csrs_pkg::cfg_t         cfg;
  csrs_pkg::sched_state_t state;
  csrs_pkg::sched_state_t state_next;
  csrs_pkg::item_t        in_item;
  csrs_pkg::result_t      step_result;
  csrs_pkg::result_t      result;
  logic                   in_full;
  logic                   advance;

  assign cfg_ready = 1'b1;

  // Move the held item into the result register when the result slot
  // is empty or is being taken this cycle.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id             <= csrs_pkg::OWN_ID_RESET;
      cfg.ping_slot_ticks    <= csrs_pkg::PING_SLOT_RESET;
      cfg.read_timeout_ticks <= csrs_pkg::READ_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csrs_pkg::CFG_OWN_ID:       cfg.own_id             <= cfg_data[7:0];
        csrs_pkg::CFG_PING_SLOT:    cfg.ping_slot_ticks    <= cfg_data;
        csrs_pkg::CFG_READ_TIMEOUT: cfg.read_timeout_ticks <= cfg_data;
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  // Input register: load whenever it is empty or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item.opcode        <= opcode;
      in_item.entry_id      <= entry_id;
      in_item.first_entry   <= first_entry;
      in_item.last_entry    <= last_entry;
      in_item.status_source <= status_source;
    end
  end

  csrs_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (in_item),
    .state_next (state_next),
    .result     (step_result)
  );

  // Scheduler state: advance once per item that moves to the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode           <= csrs_pkg::MODE_IDLE;
      state.slot_id        <= '0;
      state.predecessor_id <= csrs_pkg::NO_PRED;
      state.own_found      <= 1'b0;
      state.elapsed_ticks  <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign send_response    = result.send_response;
  assign response_dropped = result.response_dropped;
  assign wait_mode        = result.wait_mode;

  // A reply is never both sent and dropped.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(send_response && response_dropped))
    else $error("send and drop in the same result");

  // Sending or dropping always leaves the scheduler idle.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (send_response || response_dropped)) |->
      (wait_mode == csrs_pkg::WAIT_IDLE))
    else $error("reply decided but scheduler not idle");

  // A held item stays in the input register until it advances.
  assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> in_full)
    else $error("input item lost while stalled");

  // Scheduler state only changes when an item advances.
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without an item");

  // The reported wait mode matches the stored mode.
  assert property (@(posedge clk) disable iff (rst)
    $past(advance) |-> (wait_mode == csrs_pkg::mode_code(state.mode)))
    else $error("wait_mode disagrees with state");

endmodule
